FILE: sv/octal_line_pair_word_parser_top_macros.svh
// Assertion helpers shared by the queue and pair-state modules.
// Each use samples on clk_i and is masked while rst_ni is low.
`ifndef OCTAL_LINE_PAIR_WORD_PARSER_TOP_MACROS_SVH
`define OCTAL_LINE_PAIR_WORD_PARSER_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define OLP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("olp: check failed");

// Check that a condition never holds outside reset.
`define OLP_ASSERT_NEVER(label, cond) \
  `OLP_ASSERT(label, !(cond))

`endif

FILE: sv/olp_pkg.sv
package olp_pkg;

  // Default number of octal digits carried by one line
  localparam int DIGITS_PER_LINE = 3;

  // Depth of the queues between the stages
  localparam int QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_SEVEN   = 8'd55;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  // Line counter limits
  localparam logic [15:0] LINE_FIRST = 16'd1;
  localparam logic [15:0] LINE_MAX   = 16'hFFFF;

  // Input op codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  // Character class worked out by the front stage
  typedef enum logic [2:0] {
    CLS_EOF,
    CLS_NEWLINE,
    CLS_OCTAL,
    CLS_NONOCTAL,
    CLS_OTHER
  } cls_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NONOCTAL   = 3'd1,
    ST_TOO_MANY   = 3'd2,
    ST_TOO_FEW    = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_e;

  // Classified word passed from front to back
  typedef struct packed {
    cls_e       cls;
    logic [2:0] digit;
  } item_t;

  // Result word
  typedef struct packed {
    status_e     status;
    logic [5:0]  id_value;
    logic [11:0] word_value;
    logic [15:0] line_number;
  } res_t;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);

endpackage

FILE: sv/olp_fifo.sv
`include "octal_line_pair_word_parser_top_macros.svh"

module olp_fifo import olp_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CntFull);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `OLP_ASSERT_NEVER(a_count_range, count_q > CntFull)
  `OLP_ASSERT(a_write_fills, (do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
  `OLP_ASSERT(a_read_drains, (do_rd && !do_wr) |=> (count_q == $past(count_q) - 1'b1))

endmodule

FILE: sv/olp_front.sv
module olp_front import olp_pkg::*; (
  input  logic       push_i,
  input  logic       op_i,
  input  logic [7:0] char_code_i,
  input  logic       queue_full_i,
  output logic       full_o,
  output logic       item_valid_o,
  output item_t      item_o
);

  // Accept while the queue towards the back has room
  assign full_o       = queue_full_i;
  assign item_valid_o = push_i && !queue_full_i;

  // Classify the character
  always_comb begin
    item_o.digit = char_code_i[2:0];
    if (op_i == OP_EOF) begin
      item_o.cls = CLS_EOF;
    end else if (char_code_i == CH_NEWLINE) begin
      item_o.cls = CLS_NEWLINE;
    end else if (char_code_i >= CH_ZERO && char_code_i <= CH_SEVEN) begin
      item_o.cls = CLS_OCTAL;
    end else if (char_code_i > CH_SEVEN && char_code_i <= CH_NINE) begin
      item_o.cls = CLS_NONOCTAL;
    end else begin
      item_o.cls = CLS_OTHER;
    end
  end

endmodule

FILE: sv/olp_back.sv
`include "octal_line_pair_word_parser_top_macros.svh"

module olp_back import olp_pkg::*; #(
  parameter int DigitsPerLine = DIGITS_PER_LINE
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  take_i,
  input  item_t item_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  localparam int CntW = $clog2(DigitsPerLine + 1);
  localparam logic [CntW-1:0] CntLine = CntW'(DigitsPerLine);

  logic            second_half_q, second_half_d;
  logic [CntW-1:0] digit_count_q, digit_count_d;
  logic [5:0]      id_digits_q, id_digits_d;
  logic [11:0]     word_digits_q, word_digits_d;
  logic [15:0]     line_counter_q, line_counter_d;
  logic            discard_rest_q, discard_rest_d;
  logic [15:0]     line_next;

  assign line_next = (line_counter_q != LINE_MAX) ? line_counter_q + 16'd1 : line_counter_q;

  // Work out the next pair state and any result
  always_comb begin
    second_half_d  = second_half_q;
    digit_count_d  = digit_count_q;
    id_digits_d    = id_digits_q;
    word_digits_d  = word_digits_q;
    line_counter_d = line_counter_q;
    discard_rest_d = discard_rest_q;
    res_valid_o       = 1'b0;
    res_o.status      = ST_OK;
    res_o.id_value    = '0;
    res_o.word_value  = '0;
    res_o.line_number = line_counter_q;

    if (take_i) begin
      case (item_i.cls)
        CLS_EOF: begin
          if (!discard_rest_q) begin
            if (digit_count_q != '0 && digit_count_q < CntLine) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_TOO_FEW;
            end else if (digit_count_q != '0 && second_half_q) begin
              res_valid_o      = 1'b1;
              res_o.id_value   = id_digits_q;
              res_o.word_value = word_digits_q;
            end else if (digit_count_q != '0 || second_half_q) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_INCOMPLETE;
            end
          end
          // Return to reset state for a new stream
          second_half_d  = 1'b0;
          digit_count_d  = '0;
          id_digits_d    = '0;
          word_digits_d  = '0;
          line_counter_d = LINE_FIRST;
          discard_rest_d = 1'b0;
        end
        CLS_NEWLINE: begin
          line_counter_d = line_next;
          if (discard_rest_q) begin
            discard_rest_d = 1'b0;
          end else if (digit_count_q == '0) begin
            // empty line: skip
          end else if (digit_count_q < CntLine) begin
            res_valid_o   = 1'b1;
            res_o.status  = ST_TOO_FEW;
            second_half_d = 1'b0;
            digit_count_d = '0;
            id_digits_d   = '0;
            word_digits_d = '0;
          end else if (!second_half_q) begin
            second_half_d = 1'b1;
            digit_count_d = '0;
          end else begin
            res_valid_o      = 1'b1;
            res_o.id_value   = id_digits_q;
            res_o.word_value = word_digits_q;
            second_half_d    = 1'b0;
            digit_count_d    = '0;
            id_digits_d      = '0;
            word_digits_d    = '0;
          end
        end
        CLS_NONOCTAL, CLS_OCTAL: begin
          if (!discard_rest_q) begin
            if (item_i.cls == CLS_NONOCTAL || digit_count_q >= CntLine) begin
              // Drop the pair and skip to the end of the line
              res_valid_o    = 1'b1;
              res_o.status   = (item_i.cls == CLS_NONOCTAL) ? ST_NONOCTAL : ST_TOO_MANY;
              second_half_d  = 1'b0;
              digit_count_d  = '0;
              id_digits_d    = '0;
              word_digits_d  = '0;
              discard_rest_d = 1'b1;
            end else begin
              if (digit_count_q == '0) begin
                if (!second_half_q) begin
                  id_digits_d = {id_digits_q[5:3], item_i.digit};
                end else begin
                  id_digits_d = {item_i.digit, id_digits_q[2:0]};
                end
              end else begin
                word_digits_d = {word_digits_q[8:0], item_i.digit};
              end
              digit_count_d = digit_count_q + 1'b1;
            end
          end
        end
        default: begin
          // other characters are ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_half_q  <= 1'b0;
      digit_count_q  <= '0;
      id_digits_q    <= '0;
      word_digits_q  <= '0;
      line_counter_q <= LINE_FIRST;
      discard_rest_q <= 1'b0;
    end else begin
      second_half_q  <= second_half_d;
      digit_count_q  <= digit_count_d;
      id_digits_q    <= id_digits_d;
      word_digits_q  <= word_digits_d;
      line_counter_q <= line_counter_d;
      discard_rest_q <= discard_rest_d;
    end
  end

  `OLP_ASSERT_NEVER(a_count_limit, digit_count_q > CntLine)
  `OLP_ASSERT(a_eof_resets, (take_i && item_i.cls == CLS_EOF) |=>
    (line_counter_q == LINE_FIRST && !discard_rest_q && digit_count_q == '0))
  `OLP_ASSERT(a_line_monotonic, (take_i && item_i.cls != CLS_EOF) |=>
    (line_counter_q >= $past(line_counter_q)))

endmodule

FILE: sv/octal_line_pair_word_parser_top.sv
// Octal line-pair word parser.
// Input channel: push / full with op_i and char_code_i, one character or an
// end-of-stream marker (op_i high) per word. A word is taken at a clock edge
// with push high and full low.
// Result channel: empty / pop with status_o, id_value_o, word_value_o and
// line_number_o; the oldest result is shown while empty is low and leaves at
// an edge with pop high.
// Throughput: one input word per cycle, sustained, while results are popped.
// Each word passes through registered queues: the classifier writes a
// two-entry input queue, and the pair-state stage reads it and writes any
// result into a two-entry result queue.
// If the receiver stops popping, the result queue fills, the pair-state stage
// holds, the input queue fills and full rises; nothing is lost.
// Reset clears both queues, the pair state and discard flag, and sets the
// line counter to one. An end-of-stream marker does the same to the pair
// state after giving its result, so a new stream may follow at once.
module octal_line_pair_word_parser_top import olp_pkg::*; #(
  parameter int DigitsPerLine = DIGITS_PER_LINE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [7:0]  char_code_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [5:0]  id_value_o,
  output logic [11:0] word_value_o,
  output logic [15:0] line_number_o
);

  logic  in_q_full, in_valid, mid_empty, res_full, take, res_valid;
  item_t in_item, mid_item;
  res_t  res, out_res;

  olp_front u_front (
    .push_i       (push),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .queue_full_i (in_q_full),
    .full_o       (full),
    .item_valid_o (in_valid),
    .item_o       (in_item)
  );

  olp_fifo #(.Width(ITEM_W), .Depth(QUEUE_DEPTH)) u_in_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_valid),
    .wr_data_i (in_item),
    .full_o    (in_q_full),
    .rd_en_i   (take),
    .rd_data_o (mid_item),
    .empty_o   (mid_empty)
  );

  // Advance the back stage only when a result slot is free
  assign take = !mid_empty && !res_full;

  olp_back #(.DigitsPerLine(DigitsPerLine)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (mid_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  olp_fifo #(.Width(RES_W), .Depth(QUEUE_DEPTH)) u_res_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (out_res),
    .empty_o   (empty)
  );

  assign status_o      = out_res.status;
  assign id_value_o    = out_res.id_value;
  assign word_value_o  = out_res.word_value;
  assign line_number_o = out_res.line_number;

endmodule

FILE: tb/octal_line_pair_word_parser_top_tb.sv
module octal_line_pair_word_parser_top_tb;
  import olp_pkg::*;

  localparam int RandomItems    = 1650;
  localparam int HoldOffCycles  = 400;
  localparam int WatchdogLimit  = 3000;
  localparam int DrainCycles    = 8;

  // One row of the directed table; typed rows carry their result by hand
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    bit         typed;
    res_t       res;
  } row_t;

  localparam res_t NO_RES = '0;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        op_i;
  logic [7:0]  char_code_i;
  logic        empty;
  logic        pop;
  logic [2:0]  status_o;
  logic [5:0]  id_value_o;
  logic [11:0] word_value_o;
  logic [15:0] line_number_o;

  // Side channel telling the monitor that the current word has a typed result
  bit   row_typed;
  res_t row_res;

  // Parser state as predicted
  bit          pr_second;
  logic [2:0]  pr_count;
  logic [5:0]  pr_id;
  logic [11:0] pr_word;
  logic [15:0] pr_line;
  bit          pr_discard;

  res_t pending_results[$];

  int  mismatches;
  int  items_sent;
  int  results_checked;
  int  words_ok;
  int  errors_seen;
  int  quiet_cycles;
  bit  tx_no_idle;
  bit  rx_no_idle;
  bit  hold_off_req;

  row_t dir_rows [25] = '{
    '{OP_CHAR, "7", 1'b0, NO_RES},
    '{OP_CHAR, "7", 1'b0, NO_RES},
    '{OP_CHAR, "7", 1'b0, NO_RES},
    '{OP_CHAR, CH_NEWLINE, 1'b0, NO_RES},
    '{OP_CHAR, "7", 1'b0, NO_RES},
    '{OP_CHAR, "7", 1'b0, NO_RES},
    '{OP_CHAR, 8'hFF, 1'b0, NO_RES},
    '{OP_CHAR, "7", 1'b0, NO_RES},
    '{OP_CHAR, CH_NEWLINE, 1'b1, '{ST_OK, 6'o77, 12'o7777, 16'd2}},
    '{OP_CHAR, CH_NEWLINE, 1'b0, NO_RES},
    '{OP_CHAR, "9", 1'b1, '{ST_NONOCTAL, 6'd0, 12'd0, 16'd4}},
    '{OP_CHAR, "0", 1'b0, NO_RES},
    '{OP_CHAR, CH_NEWLINE, 1'b0, NO_RES},
    '{OP_CHAR, "1", 1'b0, NO_RES},
    '{OP_CHAR, "2", 1'b0, NO_RES},
    '{OP_CHAR, "3", 1'b0, NO_RES},
    '{OP_CHAR, "4", 1'b1, '{ST_TOO_MANY, 6'd0, 12'd0, 16'd5}},
    '{OP_CHAR, CH_NEWLINE, 1'b0, NO_RES},
    '{OP_CHAR, "5", 1'b0, NO_RES},
    '{OP_CHAR, CH_NEWLINE, 1'b1, '{ST_TOO_FEW, 6'd0, 12'd0, 16'd6}},
    '{OP_CHAR, 8'h00, 1'b0, NO_RES},
    '{OP_CHAR, "1", 1'b0, NO_RES},
    '{OP_CHAR, "2", 1'b0, NO_RES},
    '{OP_CHAR, "3", 1'b0, NO_RES},
    '{OP_EOF, 8'hA5, 1'b1, '{ST_INCOMPLETE, 6'd0, 12'd0, 16'd7}}
  };

  octal_line_pair_word_parser_top i_dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .op_i,
    .char_code_i,
    .empty,
    .pop,
    .status_o,
    .id_value_o,
    .word_value_o,
    .line_number_o
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Return the parser to its start-of-stream state
  task automatic clear_parse();
    pr_second  = 1'b0;
    pr_count   = '0;
    pr_id      = '0;
    pr_word    = '0;
    pr_line    = LINE_FIRST;
    pr_discard = 1'b0;
  endtask

  // Drop the pair in progress
  task automatic drop_pair();
    pr_second = 1'b0;
    pr_count  = '0;
    pr_id     = '0;
    pr_word   = '0;
  endtask

  function automatic res_t make_res(status_e st, logic [5:0] id, logic [11:0] wd);
    res_t r;
    r.status      = st;
    r.id_value    = id;
    r.word_value  = wd;
    r.line_number = pr_line;
    return r;
  endfunction

  task automatic advance_line();
    if (pr_line != LINE_MAX) pr_line = pr_line + 16'd1;
  endtask

  // Predict the result, if any, of one accepted word
  task automatic parse_char(input logic op, input logic [7:0] ch,
                            output bit produced, output res_t r);
    logic [2:0] d;
    produced = 1'b0;
    r        = NO_RES;
    d        = ch[2:0];
    if (op == OP_EOF) begin
      if (!pr_discard) begin
        if (pr_count != 0 && pr_count < DIGITS_PER_LINE) begin
          r = make_res(ST_TOO_FEW, '0, '0);
          produced = 1'b1;
        end else if (pr_count != 0 && pr_second) begin
          r = make_res(ST_OK, pr_id, pr_word);
          produced = 1'b1;
        end else if (pr_count != 0 || pr_second) begin
          r = make_res(ST_INCOMPLETE, '0, '0);
          produced = 1'b1;
        end
      end
      clear_parse();
    end else if (pr_discard) begin
      if (ch == CH_NEWLINE) begin
        pr_discard = 1'b0;
        advance_line();
      end
    end else if (ch == CH_NEWLINE) begin
      if (pr_count != 0 && pr_count < DIGITS_PER_LINE) begin
        r = make_res(ST_TOO_FEW, '0, '0);
        produced = 1'b1;
        drop_pair();
      end else if (pr_count != 0) begin
        if (!pr_second) begin
          pr_second = 1'b1;
        end else begin
          r = make_res(ST_OK, pr_id, pr_word);
          produced = 1'b1;
          drop_pair();
        end
        pr_count = '0;
      end
      advance_line();
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (ch > CH_SEVEN) begin
        r = make_res(ST_NONOCTAL, '0, '0);
        produced = 1'b1;
        drop_pair();
        pr_discard = 1'b1;
      end else if (pr_count >= DIGITS_PER_LINE) begin
        r = make_res(ST_TOO_MANY, '0, '0);
        produced = 1'b1;
        drop_pair();
        pr_discard = 1'b1;
      end else begin
        if (pr_count == 0) begin
          if (!pr_second) pr_id[2:0] = d;
          else pr_id[5:3] = d;
        end else begin
          pr_word = {pr_word[8:0], d};
        end
        pr_count = pr_count + 3'd1;
      end
    end
  endtask

  // Check results, predict accepted words and watch for a stall
  always @(posedge clk_i) begin : monitor
    res_t got_res;
    res_t want;
    res_t pred;
    bit   produced;
    bit   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (pop && !empty) begin
        moved = 1'b1;
        got_res = '{status_e'(status_o), id_value_o, word_value_o, line_number_o};
        results_checked++;
        if (got_res.status == ST_OK) words_ok++;
        else errors_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none pending: status %0d id %0o word %0o line %0d",
                   $time, status_o, id_value_o, word_value_o, line_number_o);
        end else begin
          want = pending_results.pop_front();
          if (got_res !== want) begin
            mismatches++;
            $display("%0t: expected status %0d id %0o word %0o line %0d,",
                     $time, want.status, want.id_value, want.word_value,
                     want.line_number);
            $display("%0t:      got status %0d id %0o word %0o line %0d",
                     $time, status_o, id_value_o, word_value_o, line_number_o);
          end
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        parse_char(op_i, char_code_i, produced, pred);
        if (row_typed) pending_results.push_back(row_res);
        else if (produced) pending_results.push_back(pred);
      end
      // Stop the run if nothing moves for too long
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word and hold it until taken
  task automatic send(input logic op, input logic [7:0] ch, input bit typed, input res_t res);
    int g;
    g = pick_gap(tx_no_idle);
    repeat (g) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push        <= 1'b1;
    op_i        <= op;
    char_code_i <= ch;
    row_typed   <= typed;
    row_res     <= res;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] ch);
    send(OP_CHAR, ch, 1'b0, NO_RES);
  endtask

  task automatic send_eof();
    send(OP_EOF, 8'($urandom_range(0, 255)), 1'b0, NO_RES);
  endtask

  task automatic send_digit(input int d);
    send_char(CH_ZERO + 8'(d));
  endtask

  // A byte that is neither a digit nor a newline
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_NEWLINE);
    return c;
  endfunction

  // One stream of lines, mostly well formed, ending in end-of-stream mostly
  task automatic send_stream();
    int n_lines;
    int kind;
    int n;
    tx_no_idle = ($urandom_range(0, 3) == 0);
    n_lines = $urandom_range(1, 10);
    for (int ln = 0; ln < n_lines; ln++) begin
      kind = $urandom_range(0, 99);
      if (kind < 86) begin
        if (kind < 62) n = DIGITS_PER_LINE;
        else if (kind < 70) n = 0;
        else if (kind < 78) n = $urandom_range(1, DIGITS_PER_LINE - 1);
        else n = $urandom_range(DIGITS_PER_LINE + 1, DIGITS_PER_LINE + 3);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 3) == 0) send_char(junk_char());
          send_digit($urandom_range(0, 7));
        end
        if ($urandom_range(0, 4) == 0) send_char(junk_char());
      end else if (kind < 94) begin
        // Non-octal digit after some good ones, then trailing bytes
        n = $urandom_range(0, DIGITS_PER_LINE);
        for (int k = 0; k < n; k++) send_digit($urandom_range(0, 7));
        send_digit($urandom_range(8, 9));
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) send_char(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) send_char(8'($urandom_range(0, 255)));
      end
      if (ln != n_lines - 1 || $urandom_range(0, 9) >= 3) send_char(CH_NEWLINE);
    end
    if ($urandom_range(0, 5) != 0) send_eof();
  endtask

  // Receiver: pop with random gaps, one long hold-off on request
  initial begin : receiver
    int g;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) rx_no_idle = $urandom_range(0, 1);
      g = pick_gap(rx_no_idle);
      repeat (g) begin
        @(negedge clk_i);
        pop <= 1'b0;
      end
      @(negedge clk_i);
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    op_i         = OP_CHAR;
    char_code_i  = '0;
    row_typed    = 1'b0;
    row_res      = NO_RES;
    tx_no_idle   = 1'b0;
    rx_no_idle   = 1'b0;
    hold_off_req = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    results_checked = 0;
    words_ok     = 0;
    errors_seen  = 0;
    clear_parse();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      send(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random streams, with the receiver held off once early on
    hold_off_req = 1'b1;
    while (items_sent < RandomItems + $size(dir_rows)) send_stream();

    @(negedge clk_i);
    push <= 1'b0;

    // Drain, then allow for words still in flight
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    // Anything still queued in the block has no prediction
    if (!empty) begin
      mismatches++;
      $display("%0t: expected no result left, got status %0d id %0o word %0o line %0d",
               $time, status_o, id_value_o, word_value_o, line_number_o);
    end

    $display("Sent %0d input words, checked %0d results (%0d words, %0d error reports)",
             items_sent, results_checked, words_ok, errors_seen);
    $display("Covered every status, end of stream mid-line and a full queue under hold-off");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/olp_pkg.sv
sv/olp_fifo.sv
sv/olp_front.sv
sv/olp_back.sv
sv/octal_line_pair_word_parser_top.sv
tb/octal_line_pair_word_parser_top_tb.sv
